FILE: sv/dcfr_pkg.sv
// Package for the disk command frame receiver.
// Holds the parser phase codes, event codes, command letters and the command decode.
// No dependencies.
package dcfr_pkg;

    localparam int PHASE_W = 5;
    localparam int EVENT_W = 5;
    localparam int LEFT_W  = 17;

    localparam int LOGICAL_SECTOR_BYTES  = 128;
    localparam int PHYSICAL_SECTOR_BYTES = 512;

    localparam logic [LEFT_W-1:0] LOGICAL_LEFT  = LEFT_W'(LOGICAL_SECTOR_BYTES);
    localparam logic [LEFT_W-1:0] PHYSICAL_LEFT = LEFT_W'(PHYSICAL_SECTOR_BYTES + 1);
    localparam logic [LEFT_W-1:0] MEM_FULL_LEFT = LEFT_W'(65536);

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
    localparam logic [PHASE_W-1:0] PH_PRESENT   = 5'd1;
    localparam logic [PHASE_W-1:0] PH_COMMAND   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SECTOR    = 5'd3;
    localparam logic [PHASE_W-1:0] PH_TRACK     = 5'd4;
    localparam logic [PHASE_W-1:0] PH_DRIVE     = 5'd5;
    localparam logic [PHASE_W-1:0] PH_DATA      = 5'd6;
    localparam logic [PHASE_W-1:0] PH_ADDR_H    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_ADDR_L    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_LEN_H     = 5'd9;
    localparam logic [PHASE_W-1:0] PH_LEN_L     = 5'd10;
    localparam logic [PHASE_W-1:0] PH_DATA_MEM  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_FIND      = 5'd12;
    localparam logic [PHASE_W-1:0] PH_LEN_NAME  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_DATA_NAME = 5'd14;
    localparam logic [PHASE_W-1:0] PH_WP        = 5'd15;
    localparam logic [PHASE_W-1:0] PH_CRC       = 5'd16;
    localparam logic [PHASE_W-1:0] PH_RESP      = 5'd17;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_IGNORED   = 5'd0;
    localparam logic [EVENT_W-1:0] EV_PRESENCE  = 5'd1;
    localparam logic [EVENT_W-1:0] EV_CMD_OK    = 5'd2;
    localparam logic [EVENT_W-1:0] EV_CMD_REJ   = 5'd3;
    localparam logic [EVENT_W-1:0] EV_DRV_SEC   = 5'd4;
    localparam logic [EVENT_W-1:0] EV_TRACK     = 5'd5;
    localparam logic [EVENT_W-1:0] EV_DRIVE     = 5'd6;
    localparam logic [EVENT_W-1:0] EV_SEC_BYTE  = 5'd7;
    localparam logic [EVENT_W-1:0] EV_ADDRESS   = 5'd8;
    localparam logic [EVENT_W-1:0] EV_LENGTH    = 5'd9;
    localparam logic [EVENT_W-1:0] EV_MEM_WRITE = 5'd10;
    localparam logic [EVENT_W-1:0] EV_FIND      = 5'd11;
    localparam logic [EVENT_W-1:0] EV_NAME_LEN  = 5'd12;
    localparam logic [EVENT_W-1:0] EV_NAME_BYTE = 5'd13;
    localparam logic [EVENT_W-1:0] EV_WPROT     = 5'd14;
    localparam logic [EVENT_W-1:0] EV_ACK       = 5'd15;
    localparam logic [EVENT_W-1:0] EV_NAK       = 5'd16;

    // Input modes
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_ENTER = 2'd1;
    localparam logic [1:0] MODE_LEAVE = 2'd2;
    localparam logic [1:0] MODE_DONE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_EXTRA    = 1'b0;
    localparam logic CFG_PRESENCE = 1'b1;

    // Command letters
    localparam logic [7:0] CMD_B    = 8'h42;
    localparam logic [7:0] CMD_STAR = 8'h2A;
    localparam logic [7:0] CMD_AT   = 8'h40;
    localparam logic [7:0] CMD_Q    = 8'h51;
    localparam logic [7:0] CMD_R    = 8'h52;
    localparam logic [7:0] CMD_T    = 8'h54;
    localparam logic [7:0] CMD_W    = 8'h57;
    localparam logic [7:0] CMD_S    = 8'h53;
    localparam logic [7:0] CMD_F    = 8'h46;
    localparam logic [7:0] CMD_I    = 8'h49;
    localparam logic [7:0] CMD_U    = 8'h55;
    localparam logic [7:0] CMD_C    = 8'h43;
    localparam logic [7:0] CMD_J    = 8'h4A;
    localparam logic [7:0] CMD_G    = 8'h47;
    localparam logic [7:0] CMD_H    = 8'h48;
    localparam logic [7:0] CMD_P    = 8'h50;
    localparam logic [7:0] CMD_K    = 8'h4B;
    localparam logic [7:0] CMD_L    = 8'h4C;
    localparam logic [7:0] CMD_M    = 8'h4D;
    localparam logic [7:0] CMD_N    = 8'h4E;

    localparam logic [7:0] NAME_NONE = 8'hFF;

    // Phase that follows a command letter; PH_PRESENT marks a rejected letter.
    function automatic logic [PHASE_W-1:0] command_phase(input logic [7:0] c, input logic ex);
        logic [PHASE_W-1:0] nx;
        begin
            case (c)
                CMD_B, CMD_STAR, CMD_AT:                     nx = PH_CRC;
                CMD_Q, CMD_R, CMD_T, CMD_W, CMD_S, CMD_F:    nx = PH_SECTOR;
                CMD_I:                                       nx = PH_DRIVE;
                CMD_U, CMD_C, CMD_J:                         nx = PH_ADDR_H;
                CMD_G, CMD_H, CMD_P:                         nx = ex ? PH_DRIVE : PH_PRESENT;
                CMD_K:                                       nx = ex ? PH_CRC : PH_PRESENT;
                CMD_L:                                       nx = ex ? PH_FIND : PH_PRESENT;
                CMD_M, CMD_N:                                nx = ex ? PH_LEN_NAME : PH_PRESENT;
                default:                                     nx = PH_PRESENT;
            endcase
            return nx;
        end
    endfunction

endpackage

FILE: sv/disk_command_frame_receiver.sv
// Disk command frame receiver: host-link byte parser with XOR checksum check.
// Uses dcfr_pkg for phase and event codes and the command decode.
//
//  channel   handshake                  payload
//  -------   ------------------------   ----------------------------------------------
//  in        in_valid / in_ready        mode, rx_byte
//  out       out_valid / out_ready      event_res, phase, command_letter, drive_number,
//                                       sector_number, track_number, mem_address,
//                                       transfer_length, data_byte, buffer_index,
//                                       flag_byte, running_checksum
//  cfg       cfg_we (no handshake)      cfg_index, cfg_data
//
// One item per cycle unless the output stalls; the parser state and result register load
// at the same edge, so each item shows up on the output in the cycle after it is accepted.
// in_ready is high while the result register is empty or being taken this cycle.
// Reset clears the parser state, the configuration registers and out_valid.
// A stall on the output holds the result and the parser state until it is taken.
module disk_command_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  event_res,
    output logic [4:0]  phase,
    output logic [7:0]  command_letter,
    output logic [7:0]  drive_number,
    output logic [5:0]  sector_number,
    output logic [7:0]  track_number,
    output logic [15:0] mem_address,
    output logic [15:0] transfer_length,
    output logic [7:0]  data_byte,
    output logic [9:0]  buffer_index,
    output logic [7:0]  flag_byte,
    output logic [7:0]  running_checksum,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                          extra_reg;
    logic [7:0]                    presence_reg;

    logic [dcfr_pkg::PHASE_W-1:0]  phase_reg,   phase_next;
    logic [7:0]                    command_reg, command_next;
    logic [7:0]                    xor_reg,     xor_next;
    logic [dcfr_pkg::LEFT_W-1:0]   left_reg,    left_next;
    logic [7:0]                    drive_reg,   drive_next;
    logic [5:0]                    sector_reg,  sector_next;
    logic [7:0]                    track_reg,   track_next;
    logic [15:0]                   address_reg, address_next;
    logic [15:0]                   length_reg,  length_next;
    logic [9:0]                    bufpos_reg,  bufpos_next;
    logic [7:0]                    flag_reg,    flag_next;

    logic                          out_valid_reg;
    logic [dcfr_pkg::EVENT_W-1:0]  event_reg,   event_next;
    logic [7:0]                    dbyte_reg,   dbyte_next;
    logic [15:0]                   maddr_reg,   maddr_next;
    logic [9:0]                    bidx_reg,    bidx_next;

    logic                          accept;
    logic [dcfr_pkg::PHASE_W-1:0]  cmd_phase;
    logic [1:0]                    drv_sel;
    logic                          use_idx, use_addr;
    logic [9:0]                    idx_at;
    logic [15:0]                   len_word;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cmd_phase = dcfr_pkg::command_phase(rx_byte, extra_reg);
    assign len_word  = {length_reg[15:8], rx_byte};

    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        xor_next     = xor_reg;
        left_next    = left_reg;
        drive_next   = drive_reg;
        sector_next  = sector_reg;
        track_next   = track_reg;
        address_next = address_reg;
        length_next  = length_reg;
        bufpos_next  = bufpos_reg;
        flag_next    = flag_reg;
        event_next   = dcfr_pkg::EV_IGNORED;
        dbyte_next   = 8'd0;
        use_idx      = 1'b0;
        use_addr     = 1'b0;
        idx_at       = 10'd0;
        drv_sel      = rx_byte[7:6];

        case (mode)
            dcfr_pkg::MODE_ENTER: phase_next = dcfr_pkg::PH_PRESENT;
            dcfr_pkg::MODE_LEAVE: phase_next = dcfr_pkg::PH_IDLE;
            dcfr_pkg::MODE_DONE:
            begin
                if (phase_reg == dcfr_pkg::PH_RESP)
                begin
                    phase_next = dcfr_pkg::PH_COMMAND;
                end
            end
            default:
            begin
                case (phase_reg)
                    dcfr_pkg::PH_PRESENT:
                    begin
                        if (rx_byte == presence_reg)
                        begin
                            phase_next = dcfr_pkg::PH_COMMAND;
                            event_next = dcfr_pkg::EV_PRESENCE;
                        end
                    end
                    dcfr_pkg::PH_COMMAND:
                    begin
                        command_next = rx_byte;
                        xor_next     = rx_byte;
                        // a command letter wins over an equal presence byte
                        if (cmd_phase != dcfr_pkg::PH_PRESENT)
                        begin
                            phase_next = cmd_phase;
                            event_next = dcfr_pkg::EV_CMD_OK;
                        end
                        else if (rx_byte == presence_reg)
                        begin
                            event_next = dcfr_pkg::EV_PRESENCE;
                        end
                        else
                        begin
                            phase_next = dcfr_pkg::PH_PRESENT;
                            event_next = dcfr_pkg::EV_CMD_REJ;
                        end
                    end
                    dcfr_pkg::PH_SECTOR:
                    begin
                        // swap drives 1 and 2
                        if (drv_sel == 2'd1 || drv_sel == 2'd2)
                        begin
                            drv_sel = drv_sel ^ 2'd3;
                        end
                        drive_next  = {6'd0, drv_sel};
                        sector_next = rx_byte[5:0];
                        xor_next    = xor_reg ^ rx_byte;
                        phase_next  = dcfr_pkg::PH_TRACK;
                        event_next  = dcfr_pkg::EV_DRV_SEC;
                    end
                    dcfr_pkg::PH_TRACK:
                    begin
                        track_next = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        event_next = dcfr_pkg::EV_TRACK;
                        if (command_reg == dcfr_pkg::CMD_T || command_reg == dcfr_pkg::CMD_W)
                        begin
                            bufpos_next = 10'd0;
                            left_next   = dcfr_pkg::LOGICAL_LEFT;
                            phase_next  = dcfr_pkg::PH_DATA;
                        end
                        else if (command_reg == dcfr_pkg::CMD_S)
                        begin
                            bufpos_next = 10'd0;
                            left_next   = dcfr_pkg::PHYSICAL_LEFT;
                            phase_next  = dcfr_pkg::PH_DATA;
                        end
                        else
                        begin
                            phase_next = dcfr_pkg::PH_CRC;
                        end
                    end
                    dcfr_pkg::PH_DRIVE:
                    begin
                        drive_next = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        event_next = dcfr_pkg::EV_DRIVE;
                        phase_next = (command_reg == dcfr_pkg::CMD_H) ? dcfr_pkg::PH_WP
                                                                      : dcfr_pkg::PH_CRC;
                    end
                    dcfr_pkg::PH_DATA, dcfr_pkg::PH_DATA_NAME:
                    begin
                        event_next  = (phase_reg == dcfr_pkg::PH_DATA) ? dcfr_pkg::EV_SEC_BYTE
                                                                       : dcfr_pkg::EV_NAME_BYTE;
                        dbyte_next  = rx_byte;
                        use_idx     = 1'b1;
                        idx_at      = bufpos_reg;
                        bufpos_next = bufpos_reg + 10'd1;
                        xor_next    = xor_reg ^ rx_byte;
                        if (left_reg <= dcfr_pkg::LEFT_W'(1))
                        begin
                            left_next  = '0;
                            phase_next = dcfr_pkg::PH_CRC;
                        end
                        else
                        begin
                            left_next = left_reg - dcfr_pkg::LEFT_W'(1);
                        end
                    end
                    dcfr_pkg::PH_ADDR_H:
                    begin
                        address_next = {rx_byte, 8'd0};
                        xor_next     = xor_reg ^ rx_byte;
                        phase_next   = dcfr_pkg::PH_ADDR_L;
                        event_next   = dcfr_pkg::EV_ADDRESS;
                    end
                    dcfr_pkg::PH_ADDR_L:
                    begin
                        address_next = {address_reg[15:8], rx_byte};
                        xor_next     = xor_reg ^ rx_byte;
                        event_next   = dcfr_pkg::EV_ADDRESS;
                        phase_next   = (command_reg == dcfr_pkg::CMD_J) ? dcfr_pkg::PH_CRC
                                                                        : dcfr_pkg::PH_LEN_H;
                    end
                    dcfr_pkg::PH_LEN_H:
                    begin
                        length_next = {rx_byte, 8'd0};
                        xor_next    = xor_reg ^ rx_byte;
                        phase_next  = dcfr_pkg::PH_LEN_L;
                        event_next  = dcfr_pkg::EV_LENGTH;
                    end
                    dcfr_pkg::PH_LEN_L:
                    begin
                        length_next = len_word;
                        xor_next    = xor_reg ^ rx_byte;
                        event_next  = dcfr_pkg::EV_LENGTH;
                        if (command_reg == dcfr_pkg::CMD_C)
                        begin
                            phase_next = dcfr_pkg::PH_CRC;
                        end
                        else
                        begin
                            // zero length means a full 64K transfer
                            left_next  = (len_word == 16'd0) ? dcfr_pkg::MEM_FULL_LEFT
                                                             : {1'b0, len_word};
                            phase_next = dcfr_pkg::PH_DATA_MEM;
                        end
                    end
                    dcfr_pkg::PH_DATA_MEM:
                    begin
                        event_next   = dcfr_pkg::EV_MEM_WRITE;
                        dbyte_next   = rx_byte;
                        use_addr     = 1'b1;
                        address_next = address_reg + 16'd1;
                        xor_next     = xor_reg ^ rx_byte;
                        if (left_reg <= dcfr_pkg::LEFT_W'(1))
                        begin
                            left_next  = '0;
                            phase_next = dcfr_pkg::PH_CRC;
                        end
                        else
                        begin
                            left_next = left_reg - dcfr_pkg::LEFT_W'(1);
                        end
                    end
                    dcfr_pkg::PH_FIND:
                    begin
                        flag_next  = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        phase_next = dcfr_pkg::PH_CRC;
                        event_next = dcfr_pkg::EV_FIND;
                    end
                    dcfr_pkg::PH_LEN_NAME:
                    begin
                        xor_next    = xor_reg ^ rx_byte;
                        event_next  = dcfr_pkg::EV_NAME_LEN;
                        dbyte_next  = rx_byte;
                        use_idx     = 1'b1;
                        idx_at      = 10'd0;
                        bufpos_next = 10'd1;
                        left_next   = {9'd0, rx_byte};
                        // empty name (length 0 or NAME_NONE): skip the payload
                        phase_next  = (rx_byte == 8'd0 || rx_byte == dcfr_pkg::NAME_NONE)
                                      ? dcfr_pkg::PH_CRC : dcfr_pkg::PH_DATA_NAME;
                    end
                    dcfr_pkg::PH_WP:
                    begin
                        flag_next  = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        phase_next = dcfr_pkg::PH_LEN_NAME;
                        event_next = dcfr_pkg::EV_WPROT;
                    end
                    dcfr_pkg::PH_CRC:
                    begin
                        event_next = (rx_byte == xor_reg) ? dcfr_pkg::EV_ACK : dcfr_pkg::EV_NAK;
                        phase_next = dcfr_pkg::PH_RESP;
                    end
                    default:
                    begin
                        event_next = dcfr_pkg::EV_IGNORED;
                    end
                endcase
            end
        endcase

        maddr_next = use_addr ? address_reg : address_next;
        bidx_next  = use_idx ? idx_at : bufpos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg    <= 1'b0;
            presence_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcfr_pkg::CFG_EXTRA:    extra_reg    <= cfg_data[0];
                dcfr_pkg::CFG_PRESENCE: presence_reg <= cfg_data;
                default:                extra_reg    <= extra_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dcfr_pkg::PH_IDLE;
            command_reg   <= 8'd0;
            xor_reg       <= 8'd0;
            left_reg      <= '0;
            drive_reg     <= 8'd0;
            sector_reg    <= 6'd0;
            track_reg     <= 8'd0;
            address_reg   <= 16'd0;
            length_reg    <= 16'd0;
            bufpos_reg    <= 10'd0;
            flag_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                command_reg <= command_next;
                xor_reg     <= xor_next;
                left_reg    <= left_next;
                drive_reg   <= drive_next;
                sector_reg  <= sector_next;
                track_reg   <= track_next;
                address_reg <= address_next;
                length_reg  <= length_next;
                bufpos_reg  <= bufpos_next;
                flag_reg    <= flag_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= event_next;
            dbyte_reg <= dbyte_next;
            maddr_reg <= maddr_next;
            bidx_reg  <= bidx_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = event_reg;
    assign phase            = phase_reg;
    assign command_letter   = command_reg;
    assign drive_number     = drive_reg;
    assign sector_number    = sector_reg;
    assign track_number     = track_reg;
    assign mem_address      = maddr_reg;
    assign transfer_length  = length_reg;
    assign data_byte        = dbyte_reg;
    assign buffer_index     = bidx_reg;
    assign flag_byte        = flag_reg;
    assign running_checksum = xor_reg;

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted item produced no result");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= dcfr_pkg::PH_RESP)
        else $error("parser phase out of range");

    a_ack_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == dcfr_pkg::EV_ACK || event_res == dcfr_pkg::EV_NAK))
        |-> phase == dcfr_pkg::PH_RESP)
        else $error("checksum verdict without response pending");

    a_memwrite_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == dcfr_pkg::EV_MEM_WRITE)
        |-> (phase == dcfr_pkg::PH_DATA_MEM || phase == dcfr_pkg::PH_CRC))
        else $error("memory write outside memory payload");

    a_left_zero_at_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == dcfr_pkg::PH_DATA || phase_reg == dcfr_pkg::PH_DATA_MEM)
         && mode == dcfr_pkg::MODE_BYTE && left_reg <= dcfr_pkg::LEFT_W'(1))
        |=> (phase_reg == dcfr_pkg::PH_CRC && left_reg == '0))
        else $error("payload count did not end at checksum");
`endif

endmodule

FILE: dv/disk_command_frame_receiver_test.sv
// Self-checking testbench for disk_command_frame_receiver: host-link frames in, per-byte events out.
// Carries its own model of the frame parser and checks every result field by field.
// Depends on dcfr_pkg and the disk_command_frame_receiver RTL.
module disk_command_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 100;

    typedef struct packed {
        logic [1:0] md;
        logic [7:0] data;
    } link_item_t;

    typedef struct packed {
        logic [4:0]  ev;
        logic [4:0]  ph;
        logic [7:0]  cmd;
        logic [7:0]  drv;
        logic [5:0]  sec;
        logic [7:0]  trk;
        logic [15:0] addr;
        logic [15:0] len;
        logic [7:0]  dat;
        logic [9:0]  idx;
        logic [7:0]  flg;
        logic [7:0]  sum;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = dcfr_pkg::MODE_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  event_res;
    logic [4:0]  phase;
    logic [7:0]  command_letter;
    logic [7:0]  drive_number;
    logic [5:0]  sector_number;
    logic [7:0]  track_number;
    logic [15:0] mem_address;
    logic [15:0] transfer_length;
    logic [7:0]  data_byte;
    logic [9:0]  buffer_index;
    logic [7:0]  flag_byte;
    logic [7:0]  running_checksum;
    logic        cfg_we = 1'b0;
    logic        cfg_index = dcfr_pkg::CFG_EXTRA;
    logic [7:0]  cfg_data = 8'h00;

    disk_command_frame_receiver dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_res(event_res),
        .phase(phase),
        .command_letter(command_letter),
        .drive_number(drive_number),
        .sector_number(sector_number),
        .track_number(track_number),
        .mem_address(mem_address),
        .transfer_length(transfer_length),
        .data_byte(data_byte),
        .buffer_index(buffer_index),
        .flag_byte(flag_byte),
        .running_checksum(running_checksum),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Parser model state and its copy of the configuration
    logic        cfg_extra = 1'b0;
    logic [7:0]  cfg_presence = 8'h00;
    logic [4:0]  m_phase = dcfr_pkg::PH_IDLE;
    logic [7:0]  m_cmd = 8'h00;
    logic [7:0]  m_sum = 8'h00;
    logic [16:0] m_left = '0;
    logic [7:0]  m_drive = 8'h00;
    logic [5:0]  m_sector = 6'h00;
    logic [7:0]  m_track = 8'h00;
    logic [15:0] m_addr = 16'h0000;
    logic [15:0] m_len = 16'h0000;
    logic [9:0]  m_pos = 10'h000;
    logic [7:0]  m_flag = 8'h00;

    link_item_t    pending_items[$];
    frame_result_t expected_results[$];
    link_item_t    next_item;
    frame_result_t want;

    int send_idle_pct = 31;
    int recv_idle_pct = 82;
    int items_queued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;
    int frames_built = 0;
    int acks_seen = 0;
    int naks_seen = 0;
    int cycle_count = 0;

    // Phase that a command letter leads to; PH_PRESENT when the letter is refused.
    function automatic logic [4:0] phase_after_letter(input logic [7:0] c);
        case (c)
            dcfr_pkg::CMD_B, dcfr_pkg::CMD_STAR, dcfr_pkg::CMD_AT:
                return dcfr_pkg::PH_CRC;
            dcfr_pkg::CMD_Q, dcfr_pkg::CMD_R, dcfr_pkg::CMD_T,
            dcfr_pkg::CMD_W, dcfr_pkg::CMD_S, dcfr_pkg::CMD_F:
                return dcfr_pkg::PH_SECTOR;
            dcfr_pkg::CMD_I:
                return dcfr_pkg::PH_DRIVE;
            dcfr_pkg::CMD_U, dcfr_pkg::CMD_C, dcfr_pkg::CMD_J:
                return dcfr_pkg::PH_ADDR_H;
            dcfr_pkg::CMD_G, dcfr_pkg::CMD_H, dcfr_pkg::CMD_P:
                return cfg_extra ? dcfr_pkg::PH_DRIVE : dcfr_pkg::PH_PRESENT;
            dcfr_pkg::CMD_K:
                return cfg_extra ? dcfr_pkg::PH_CRC : dcfr_pkg::PH_PRESENT;
            dcfr_pkg::CMD_L:
                return cfg_extra ? dcfr_pkg::PH_FIND : dcfr_pkg::PH_PRESENT;
            dcfr_pkg::CMD_M, dcfr_pkg::CMD_N:
                return cfg_extra ? dcfr_pkg::PH_LEN_NAME : dcfr_pkg::PH_PRESENT;
            default:
                return dcfr_pkg::PH_PRESENT;
        endcase
    endfunction

    // Advance the parser model by one item and return the result it produces.
    function automatic frame_result_t step_receiver(input logic [1:0] md, input logic [7:0] b);
        frame_result_t r;
        logic [4:0]  nx;
        logic [4:0]  ev;
        logic [7:0]  payload;
        logic [7:0]  d;
        logic        hold_addr;
        logic        hold_pos;
        logic [15:0] addr_at;
        logic [9:0]  pos_at;
        ev = dcfr_pkg::EV_IGNORED;
        payload = 8'h00;
        hold_addr = 1'b0;
        hold_pos = 1'b0;
        addr_at = 16'h0000;
        pos_at = 10'h000;
        case (md)
            dcfr_pkg::MODE_ENTER: m_phase = dcfr_pkg::PH_PRESENT;
            dcfr_pkg::MODE_LEAVE: m_phase = dcfr_pkg::PH_IDLE;
            dcfr_pkg::MODE_DONE:
            begin
                if (m_phase == dcfr_pkg::PH_RESP)
                    m_phase = dcfr_pkg::PH_COMMAND;
            end
            default:
            begin
                case (m_phase)
                    dcfr_pkg::PH_PRESENT:
                    begin
                        if (b == cfg_presence)
                        begin
                            m_phase = dcfr_pkg::PH_COMMAND;
                            ev = dcfr_pkg::EV_PRESENCE;
                        end
                    end
                    dcfr_pkg::PH_COMMAND:
                    begin
                        nx = phase_after_letter(b);
                        m_cmd = b;
                        m_sum = b;
                        if (nx != dcfr_pkg::PH_PRESENT)
                        begin
                            m_phase = nx;
                            ev = dcfr_pkg::EV_CMD_OK;
                        end
                        else if (b == cfg_presence)
                            ev = dcfr_pkg::EV_PRESENCE;
                        else
                        begin
                            m_phase = dcfr_pkg::PH_PRESENT;
                            ev = dcfr_pkg::EV_CMD_REJ;
                        end
                    end
                    dcfr_pkg::PH_SECTOR:
                    begin
                        // drives 1 and 2 trade places
                        d = {6'b0, b[7:6]};
                        if (d == 8'd1 || d == 8'd2)
                            d = d ^ 8'd3;
                        m_drive = d;
                        m_sector = b[5:0];
                        m_sum ^= b;
                        m_phase = dcfr_pkg::PH_TRACK;
                        ev = dcfr_pkg::EV_DRV_SEC;
                    end
                    dcfr_pkg::PH_TRACK:
                    begin
                        m_track = b;
                        m_sum ^= b;
                        ev = dcfr_pkg::EV_TRACK;
                        if (m_cmd == dcfr_pkg::CMD_T || m_cmd == dcfr_pkg::CMD_W)
                        begin
                            m_pos = '0;
                            m_left = dcfr_pkg::LOGICAL_LEFT;
                            m_phase = dcfr_pkg::PH_DATA;
                        end
                        else if (m_cmd == dcfr_pkg::CMD_S)
                        begin
                            m_pos = '0;
                            m_left = dcfr_pkg::PHYSICAL_LEFT;
                            m_phase = dcfr_pkg::PH_DATA;
                        end
                        else
                            m_phase = dcfr_pkg::PH_CRC;
                    end
                    dcfr_pkg::PH_DRIVE:
                    begin
                        m_drive = b;
                        m_sum ^= b;
                        ev = dcfr_pkg::EV_DRIVE;
                        m_phase = (m_cmd == dcfr_pkg::CMD_H) ? dcfr_pkg::PH_WP
                                                              : dcfr_pkg::PH_CRC;
                    end
                    dcfr_pkg::PH_DATA, dcfr_pkg::PH_DATA_NAME:
                    begin
                        ev = (m_phase == dcfr_pkg::PH_DATA) ? dcfr_pkg::EV_SEC_BYTE
                                                             : dcfr_pkg::EV_NAME_BYTE;
                        payload = b;
                        hold_pos = 1'b1;
                        pos_at = m_pos;
                        m_pos = m_pos + 10'd1;
                        m_sum ^= b;
                        if (m_left <= 17'd1)
                        begin
                            m_left = '0;
                            m_phase = dcfr_pkg::PH_CRC;
                        end
                        else
                            m_left = m_left - 17'd1;
                    end
                    dcfr_pkg::PH_ADDR_H:
                    begin
                        m_addr = {b, 8'h00};
                        m_sum ^= b;
                        m_phase = dcfr_pkg::PH_ADDR_L;
                        ev = dcfr_pkg::EV_ADDRESS;
                    end
                    dcfr_pkg::PH_ADDR_L:
                    begin
                        m_addr[7:0] = b;
                        m_sum ^= b;
                        ev = dcfr_pkg::EV_ADDRESS;
                        m_phase = (m_cmd == dcfr_pkg::CMD_J) ? dcfr_pkg::PH_CRC
                                                              : dcfr_pkg::PH_LEN_H;
                    end
                    dcfr_pkg::PH_LEN_H:
                    begin
                        m_len = {b, 8'h00};
                        m_sum ^= b;
                        m_phase = dcfr_pkg::PH_LEN_L;
                        ev = dcfr_pkg::EV_LENGTH;
                    end
                    dcfr_pkg::PH_LEN_L:
                    begin
                        m_len[7:0] = b;
                        m_sum ^= b;
                        ev = dcfr_pkg::EV_LENGTH;
                        if (m_cmd == dcfr_pkg::CMD_C)
                            m_phase = dcfr_pkg::PH_CRC;
                        else
                        begin
                            // zero length means a full 64K transfer
                            m_left = (m_len == 16'h0000) ? dcfr_pkg::MEM_FULL_LEFT
                                                         : {1'b0, m_len};
                            m_phase = dcfr_pkg::PH_DATA_MEM;
                        end
                    end
                    dcfr_pkg::PH_DATA_MEM:
                    begin
                        ev = dcfr_pkg::EV_MEM_WRITE;
                        payload = b;
                        hold_addr = 1'b1;
                        addr_at = m_addr;
                        m_addr = m_addr + 16'd1;
                        m_sum ^= b;
                        if (m_left <= 17'd1)
                        begin
                            m_left = '0;
                            m_phase = dcfr_pkg::PH_CRC;
                        end
                        else
                            m_left = m_left - 17'd1;
                    end
                    dcfr_pkg::PH_FIND:
                    begin
                        m_flag = b;
                        m_sum ^= b;
                        m_phase = dcfr_pkg::PH_CRC;
                        ev = dcfr_pkg::EV_FIND;
                    end
                    dcfr_pkg::PH_LEN_NAME:
                    begin
                        m_sum ^= b;
                        ev = dcfr_pkg::EV_NAME_LEN;
                        payload = b;
                        hold_pos = 1'b1;
                        pos_at = '0;
                        m_pos = 10'd1;
                        m_left = {9'b0, b};
                        m_phase = (b == 8'h00 || b == dcfr_pkg::NAME_NONE)
                                  ? dcfr_pkg::PH_CRC : dcfr_pkg::PH_DATA_NAME;
                    end
                    dcfr_pkg::PH_WP:
                    begin
                        m_flag = b;
                        m_sum ^= b;
                        m_phase = dcfr_pkg::PH_LEN_NAME;
                        ev = dcfr_pkg::EV_WPROT;
                    end
                    dcfr_pkg::PH_CRC:
                    begin
                        ev = (b == m_sum) ? dcfr_pkg::EV_ACK : dcfr_pkg::EV_NAK;
                        m_phase = dcfr_pkg::PH_RESP;
                    end
                    default: ;
                endcase
            end
        endcase
        r.ev   = ev;
        r.ph   = m_phase;
        r.cmd  = m_cmd;
        r.drv  = m_drive;
        r.sec  = m_sector;
        r.trk  = m_track;
        r.addr = hold_addr ? addr_at : m_addr;
        r.len  = m_len;
        r.dat  = payload;
        r.idx  = hold_pos ? pos_at : m_pos;
        r.flg  = m_flag;
        r.sum  = m_sum;
        return r;
    endfunction

    // Sender: present queued items, predict each one as it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= dcfr_pkg::MODE_BYTE;
            rx_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want = step_receiver(mode, rx_byte);
                expected_results.push_back(want);
                items_accepted++;
                if (want.ev == dcfr_pkg::EV_ACK)
                    acks_seen++;
                if (want.ev == dcfr_pkg::EV_NAK)
                    naks_seen++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    mode <= next_item.md;
                    rx_byte <= next_item.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string fname, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d: %s expected %h, got %h",
                         results_checked, fname, exp_v, act_v);
        end
    endtask

    // Receiver: take results with random back-pressure and compare with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        frame_result_t exp_r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with no item pending: event %0d phase %0d",
                                 event_res, phase);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("event_res", 16'(exp_r.ev), 16'(event_res));
                    check_field("phase", 16'(exp_r.ph), 16'(phase));
                    check_field("command_letter", 16'(exp_r.cmd), 16'(command_letter));
                    check_field("drive_number", 16'(exp_r.drv), 16'(drive_number));
                    check_field("sector_number", 16'(exp_r.sec), 16'(sector_number));
                    check_field("track_number", 16'(exp_r.trk), 16'(track_number));
                    check_field("mem_address", exp_r.addr, mem_address);
                    check_field("transfer_length", exp_r.len, transfer_length);
                    check_field("data_byte", 16'(exp_r.dat), 16'(data_byte));
                    check_field("buffer_index", 16'(exp_r.idx), 16'(buffer_index));
                    check_field("flag_byte", 16'(exp_r.flg), 16'(flag_byte));
                    check_field("running_checksum", 16'(exp_r.sum), 16'(running_checksum));
                    results_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("no progress: stopped after %0d cycles, %0d items taken, %0d results",
                     cycle_count, items_accepted, results_checked);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] letter_at(input int i);
        case (i)
            0:  return dcfr_pkg::CMD_B;
            1:  return dcfr_pkg::CMD_STAR;
            2:  return dcfr_pkg::CMD_AT;
            3:  return dcfr_pkg::CMD_Q;
            4:  return dcfr_pkg::CMD_R;
            5:  return dcfr_pkg::CMD_T;
            6:  return dcfr_pkg::CMD_W;
            7:  return dcfr_pkg::CMD_S;
            8:  return dcfr_pkg::CMD_F;
            9:  return dcfr_pkg::CMD_I;
            10: return dcfr_pkg::CMD_U;
            11: return dcfr_pkg::CMD_C;
            12: return dcfr_pkg::CMD_J;
            13: return dcfr_pkg::CMD_G;
            14: return dcfr_pkg::CMD_H;
            15: return dcfr_pkg::CMD_P;
            16: return dcfr_pkg::CMD_K;
            17: return dcfr_pkg::CMD_L;
            18: return dcfr_pkg::CMD_M;
            default: return dcfr_pkg::CMD_N;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] md, input logic [7:0] b);
        pending_items.push_back('{md: md, data: b});
        items_queued++;
    endtask

    // Queue one frame: optional noise, optional session open, command, parameters,
    // checksum and the response-finished mark; some frames are cut short and aborted.
    task automatic gen_frame(input bit full_sector);
        logic [7:0]  body[$];
        logic [7:0]  letter;
        logic [7:0]  sum;
        logic [7:0]  nlen;
        logic [15:0] addr;
        logic [15:0] len;
        int          n;
        int          r;
        int          cut;
        bit          must_cut;
        bit          with_name;
        must_cut = 1'b0;
        with_name = 1'b0;
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3))
                push_item(2'($urandom_range(3)), rand_byte());
        if (full_sector)
            letter = dcfr_pkg::CMD_S;
        else if ($urandom_range(99) < 6)
            letter = rand_byte();
        else
            letter = letter_at($urandom_range(19));
        body.push_back(letter);
        case (letter)
            dcfr_pkg::CMD_Q, dcfr_pkg::CMD_R, dcfr_pkg::CMD_F,
            dcfr_pkg::CMD_T, dcfr_pkg::CMD_W, dcfr_pkg::CMD_S:
            begin
                body.push_back(rand_byte());
                body.push_back(rand_byte());
                if (letter == dcfr_pkg::CMD_T || letter == dcfr_pkg::CMD_W)
                    n = dcfr_pkg::LOGICAL_SECTOR_BYTES;
                else if (letter == dcfr_pkg::CMD_S)
                    n = full_sector ? dcfr_pkg::PHYSICAL_SECTOR_BYTES + 1 : 24;
                else
                    n = 0;
                // long sector frames run in full only once
                if (letter == dcfr_pkg::CMD_S && !full_sector)
                    must_cut = 1'b1;
                repeat (n)
                    body.push_back(rand_byte());
            end
            dcfr_pkg::CMD_I, dcfr_pkg::CMD_G, dcfr_pkg::CMD_P, dcfr_pkg::CMD_H:
            begin
                body.push_back(rand_byte());
                if (letter == dcfr_pkg::CMD_H)
                begin
                    body.push_back(rand_byte());
                    with_name = 1'b1;
                end
            end
            dcfr_pkg::CMD_M, dcfr_pkg::CMD_N:
                with_name = 1'b1;
            dcfr_pkg::CMD_L:
                body.push_back(rand_byte());
            dcfr_pkg::CMD_U, dcfr_pkg::CMD_C, dcfr_pkg::CMD_J:
            begin
                if ($urandom_range(99) < 15)
                    addr = {8'hFF, 8'($urandom_range(8'hFA, 8'hFF))};
                else
                    addr = 16'($urandom_range(16'hFFFF));
                body.push_back(addr[15:8]);
                body.push_back(addr[7:0]);
                if (letter != dcfr_pkg::CMD_J)
                begin
                    r = $urandom_range(99);
                    if (letter == dcfr_pkg::CMD_C)
                        len = 16'($urandom_range(16'hFFFF));
                    else if (r < 8)
                    begin
                        len = 16'h0000;
                        must_cut = 1'b1;
                    end
                    else if (r < 12)
                    begin
                        len = 16'($urandom_range(256, 16'hFFFF));
                        must_cut = 1'b1;
                    end
                    else
                        len = 16'($urandom_range(1, 6));
                    body.push_back(len[15:8]);
                    body.push_back(len[7:0]);
                    if (letter == dcfr_pkg::CMD_U)
                    begin
                        n = (len == 16'h0000 || len > 16'd6) ? 12 : int'(len);
                        repeat (n)
                            body.push_back(rand_byte());
                    end
                end
            end
            default: ;
        endcase
        if (with_name)
        begin
            r = $urandom_range(99);
            if (r < 10)
                nlen = 8'h00;
            else if (r < 20)
                nlen = dcfr_pkg::NAME_NONE;
            else if (r < 95)
                nlen = 8'($urandom_range(1, 12));
            else
                nlen = 8'($urandom_range(13, 254));
            body.push_back(nlen);
            if (nlen != 8'h00 && nlen != dcfr_pkg::NAME_NONE)
                repeat (nlen)
                    body.push_back(rand_byte());
        end
        sum = 8'h00;
        foreach (body[i])
            sum ^= body[i];
        if ($urandom_range(99) < 85)
            body.push_back(sum);
        else
            body.push_back(sum ^ 8'($urandom_range(1, 255)));

        if ($urandom_range(99) < 70)
        begin
            push_item(dcfr_pkg::MODE_ENTER, rand_byte());
            push_item(dcfr_pkg::MODE_BYTE, cfg_presence);
        end
        if (must_cut)
            cut = $urandom_range(body.size() / 2, body.size() - 1);
        else if ($urandom_range(99) < 12)
            cut = $urandom_range(1, body.size() - 1);
        else
            cut = body.size();
        for (int i = 0; i < cut; i++)
            push_item(dcfr_pkg::MODE_BYTE, body[i]);
        if (cut < body.size())
            push_item($urandom_range(1) ? dcfr_pkg::MODE_ENTER : dcfr_pkg::MODE_LEAVE,
                      rand_byte());
        else
            push_item(dcfr_pkg::MODE_DONE, rand_byte());
        frames_built++;
    endtask

    // Hold until every queued item has been taken and its result checked.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == dcfr_pkg::CFG_EXTRA)
            cfg_extra = value[0];
        else
            cfg_presence = value;
    endtask

    initial
    begin : stimulus
        logic [7:0] presence_plan[6];
        logic       extra_plan[6];
        int         start_count;
        presence_plan = '{8'h00, 8'hFF, dcfr_pkg::CMD_B, 8'h00, 8'h00, 8'h00};
        extra_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int p = 3; p < 6; p++)
            presence_plan[p] = rand_byte();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_config(dcfr_pkg::CFG_EXTRA, 8'h00);
        write_config(dcfr_pkg::CFG_PRESENCE, 8'hA5);

        // directed frames with presence 0xA5 and extra commands off
        push_item(dcfr_pkg::MODE_BYTE, 8'h00);
        push_item(dcfr_pkg::MODE_DONE, 8'h00);
        push_item(dcfr_pkg::MODE_ENTER, 8'hFF);
        push_item(dcfr_pkg::MODE_BYTE, 8'hFF);
        push_item(dcfr_pkg::MODE_BYTE, 8'hA5);
        push_item(dcfr_pkg::MODE_BYTE, 8'hA5);
        push_item(dcfr_pkg::MODE_BYTE, 8'h00);
        push_item(dcfr_pkg::MODE_BYTE, 8'hA5);
        push_item(dcfr_pkg::MODE_BYTE, dcfr_pkg::CMD_R);
        push_item(dcfr_pkg::MODE_BYTE, 8'h7F);
        push_item(dcfr_pkg::MODE_BYTE, 8'hFF);
        push_item(dcfr_pkg::MODE_BYTE, dcfr_pkg::CMD_R ^ 8'h7F ^ 8'hFF);
        push_item(dcfr_pkg::MODE_DONE, 8'h00);
        push_item(dcfr_pkg::MODE_BYTE, dcfr_pkg::CMD_B);
        push_item(dcfr_pkg::MODE_BYTE, ~dcfr_pkg::CMD_B);
        push_item(dcfr_pkg::MODE_DONE, 8'hFF);
        push_item(dcfr_pkg::MODE_BYTE, dcfr_pkg::CMD_G);
        push_item(dcfr_pkg::MODE_BYTE, 8'hA5);
        // zero-length memory write from the top of memory, aborted after a wrap
        push_item(dcfr_pkg::MODE_BYTE, dcfr_pkg::CMD_U);
        push_item(dcfr_pkg::MODE_BYTE, 8'hFF);
        push_item(dcfr_pkg::MODE_BYTE, 8'hFE);
        push_item(dcfr_pkg::MODE_BYTE, 8'h00);
        push_item(dcfr_pkg::MODE_BYTE, 8'h00);
        push_item(dcfr_pkg::MODE_BYTE, 8'h12);
        push_item(dcfr_pkg::MODE_BYTE, 8'h34);
        push_item(dcfr_pkg::MODE_BYTE, 8'h56);
        push_item(dcfr_pkg::MODE_LEAVE, 8'h00);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 82;
            end
            else if (p < 4)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_config(dcfr_pkg::CFG_EXTRA, {7'b0, extra_plan[p]});
            write_config(dcfr_pkg::CFG_PRESENCE, presence_plan[p]);
            start_count = items_queued;
            if (p == 5)
                gen_frame(1'b1);
            while (items_queued - start_count < PHASE_ITEMS)
                gen_frame(1'b0);
            wait_drained();
        end

        $display("%0d items in %0d frames over 7 register settings, %0d results checked",
                 items_accepted, frames_built, results_checked);
        $display("frames closed with %0d ACK and %0d NAK, %0d field mismatches",
                 acks_seen, naks_seen, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
